FILE: rtl/atss_pkg.sv
//------------------------------------------------------------------------------
// atss_pkg
// shared types, constants and helpers for the transfer size selector
//------------------------------------------------------------------------------
`default_nettype none

package atss_pkg;

    localparam int NUM_BUCKETS_DEF = 64;
    localparam int UNIT_LOG_DEF    = 10;
    localparam int FIFO_DEPTH      = 2;

    localparam logic [1:0] CMD_CHOOSE = 2'd0;
    localparam logic [1:0] CMD_RECORD = 2'd1;
    localparam logic [1:0] CMD_INIT   = 2'd2;

    localparam logic [2:0] REG_DEFAULT_RATE = 3'd0;
    localparam logic [2:0] REG_TERM_LENGTH  = 3'd1;
    localparam logic [2:0] REG_FRACTION_LOG = 3'd2;
    localparam logic [2:0] REG_TICKS_PER_S  = 3'd3;
    localparam logic [2:0] REG_SLOW_TICKS   = 3'd4;

    localparam logic [31:0] SLOW_SIZE_LIMIT = 32'(24 << 10);
    localparam logic [31:0] MIN_BUCKET_SIZE = 32'(8 << 10);
    localparam logic [31:0] SLOW_DECREMENT  = 32'd2;

    // queued command after classification
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] request_size;
        logic [31:0] unit_size;
        logic [31:0] transferred_bytes;
        logic [31:0] delta_ticks;
    } t_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_CH_READ,
        ST_CH_WAIT,
        ST_CH_CMP,
        ST_CH_DONE,
        ST_RC_READ,
        ST_RC_WAIT,
        ST_RC_UPD,
        ST_RC_WB,
        ST_RB_READ,
        ST_RB_WAIT,
        ST_RB_WB,
        ST_RB_END,
        ST_OUT
    } t_state;

    // floor log2, zero for zero
    function automatic logic [5:0] flog2(input logic [63:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 1; i < 64; i++) begin
            if (v[i]) begin
                n = 6'(i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/atss_front.sv
//------------------------------------------------------------------------------
// atss_front
// accepts transactions, computes tick difference, queues them for the engine
//------------------------------------------------------------------------------
`default_nettype none

module atss_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [1:0]     i_cmd,
    input  wire logic [31:0]    i_request_size,
    input  wire logic [31:0]    i_unit_size,
    input  wire logic [31:0]    i_transferred_bytes,
    input  wire logic [31:0]    i_start_tick,
    input  wire logic [31:0]    i_end_tick,
    output atss_pkg::t_item     o_item,
    output logic                o_item_valid,
    input  wire logic           i_item_pop
);

    localparam int PW = $clog2(atss_pkg::FIFO_DEPTH);

    atss_pkg::t_item r_mem [atss_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;
    atss_pkg::t_item w_in;
    logic            w_push;

    assign o_ready      = (r_cnt != (PW+1)'(atss_pkg::FIFO_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign w_push       = i_valid && o_ready;
    assign o_item       = r_mem[r_rd];

    always_comb begin
        w_in.cmd               = i_cmd;
        w_in.request_size      = i_request_size;
        w_in.unit_size         = i_unit_size;
        w_in.transferred_bytes = i_transferred_bytes;
        w_in.delta_ticks       = i_end_tick - i_start_tick;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_in;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_item_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(i_item_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/atss_engine.sv
//------------------------------------------------------------------------------
// atss_engine
// bucket tables and the sequencer that carries out choose, record and init
//------------------------------------------------------------------------------
`default_nettype none

module atss_engine #(
    parameter int NUM_BUCKETS = atss_pkg::NUM_BUCKETS_DEF,
    parameter int UNIT_LOG    = atss_pkg::UNIT_LOG_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  atss_pkg::t_item     i_item,
    input  wire logic           i_item_valid,
    output logic                o_item_pop,
    input  wire logic [31:0]    i_default_rate,
    input  wire logic [7:0]     i_term_length,
    input  wire logic [3:0]     i_fraction_log,
    input  wire logic [13:0]    i_ticks_per_second,
    input  wire logic [13:0]    i_slow_ticks,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_transfer_size,
    output logic                o_busy
);

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int CW = BW + 1;
    localparam logic [CW-1:0] NB = CW'(NUM_BUCKETS);

    // bucket record: bytes, ticks, term bytes, term ticks, hits
    typedef struct packed {
        logic [63:0] bb;
        logic [63:0] bt;
        logic [63:0] tb;
        logic [63:0] tt;
        logic [31:0] hc;
    } t_entry;

    t_entry r_mem [NUM_BUCKETS];
    t_entry r_rdata;
    logic [BW-1:0] w_raddr;
    logic [BW-1:0] w_waddr;
    logic          w_we;
    t_entry        w_wdata;

    atss_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [7:0]    r_best, n_best;
    logic [63:0]   r_best_rate, n_best_rate;
    logic [31:0]   r_req, n_req;
    atss_pkg::t_item r_it, n_it;
    t_entry        r_ent, n_ent;
    logic [63:0] r_sum_b, n_sum_b, r_sum_t, n_sum_t;
    logic [63:0] r_per_b, n_per_b, r_per_t, n_per_t;
    logic [63:0] r_avg, n_avg, r_sh_b, n_sh_b, r_sh_t, n_sh_t;
    logic [31:0] r_upd, n_upd, r_last_req, n_last_req;
    logic [7:0]  r_min, n_min, r_last_b, n_last_b;
    logic [31:0] r_out, n_out;
    logic        r_fold, n_fold, r_slow, n_slow;
    logic        r_rebal, n_rebal;
    logic [7:0]  r_mod, n_mod;
    logic [2:0]  r_step, n_step;

    logic [63:0] w_rate;
    logic [8:0]  w_tl;
    logic [31:0] w_bidx;
    logic [32:0] w_min_size;
    logic [63:0] w_ms;
    logic [5:0]  w_msh;
    logic [9:0]  w_rem;
    logic [31:0] w_sh;

    assign w_rate = r_rdata.bb >> atss_pkg::flog2(r_rdata.bt);
    assign w_tl   = (i_term_length == 8'd0) ? 9'd256 : {1'b0, i_term_length};
    assign w_min_size = 33'({25'd0, r_min} + 33'd1) << UNIT_LOG;
    assign w_bidx = (r_it.unit_size >> UNIT_LOG) - 32'd1;
    assign w_msh  = atss_pkg::flog2(r_sum_t) >> atss_pkg::flog2({50'd0, i_ticks_per_second});
    assign w_ms   = r_sum_b >> w_msh;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_raddr];
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_comb begin
        n_state = r_state; n_idx = r_idx; n_best = r_best;
        n_best_rate = r_best_rate; n_req = r_req; n_it = r_it; n_ent = r_ent;
        n_sum_b = r_sum_b; n_sum_t = r_sum_t; n_per_b = r_per_b; n_per_t = r_per_t;
        n_avg = r_avg; n_sh_b = r_sh_b; n_sh_t = r_sh_t; n_upd = r_upd;
        n_last_req = r_last_req; n_min = r_min; n_last_b = r_last_b;
        n_out = r_out; n_fold = r_fold; n_slow = r_slow; n_rebal = r_rebal;
        n_mod = r_mod; n_step = r_step;
        w_rem = '0;
        w_sh  = '0;
        o_item_pop = 1'b0;
        w_raddr = r_idx[BW-1:0];
        w_waddr = r_idx[BW-1:0];
        w_we    = 1'b0;
        w_wdata = r_ent;
        unique case (r_state)
            atss_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_it = i_item;
                    unique case (i_item.cmd)
                        atss_pkg::CMD_CHOOSE: begin
                            if ({1'b0, i_item.request_size} < w_min_size) begin
                                n_out = i_item.request_size;
                                n_state = atss_pkg::ST_OUT;
                            end else if (r_last_req != '0 && r_last_req >= i_item.request_size)
                            begin
                                n_out = 32'(({24'd0, r_last_b} + 32'd1) << UNIT_LOG);
                                n_state = atss_pkg::ST_OUT;
                            end else begin
                                n_best = (r_last_req != '0) ? r_last_b : r_min;
                                n_idx = CW'(n_best);
                                n_req = i_item.request_size;
                                n_state = atss_pkg::ST_CH_READ;
                            end
                        end
                        atss_pkg::CMD_RECORD: begin
                            n_state = atss_pkg::ST_RC_READ;
                        end
                        atss_pkg::CMD_INIT: begin
                            n_idx = '0; n_sum_b = '0; n_sum_t = '0;
                            n_state = atss_pkg::ST_INIT;
                        end
                        default: n_state = atss_pkg::ST_IDLE;
                    endcase
                end
            end
            atss_pkg::ST_INIT: begin
                w_we = 1'b1;
                w_wdata = '{bb: {32'd0, i_default_rate},
                            bt: {50'd0, i_ticks_per_second},
                            tb: '0, tt: '0, hc: '0};
                n_sum_b = r_sum_b + {32'd0, i_default_rate};
                n_sum_t = r_sum_t + {50'd0, i_ticks_per_second};
                n_idx = r_idx + 1'b1;
                if (r_idx == NB - 1'b1) begin
                    n_per_b = '0; n_per_t = '0; n_upd = '0; n_min = '0;
                    n_last_req = '0; n_last_b = '0;
                    n_state = atss_pkg::ST_IDLE;
                end
            end
            // read the starting best, then walk upward
            atss_pkg::ST_CH_READ: n_state = atss_pkg::ST_CH_WAIT;
            atss_pkg::ST_CH_WAIT: begin
                n_best_rate = w_rate;
                n_idx = r_idx + 1'b1;
                w_raddr = n_idx[BW-1:0];
                n_state = atss_pkg::ST_CH_CMP;
                if (n_idx >= NB || {1'b0, r_req} < 33'({1'b0, n_idx} + 33'd1) << UNIT_LOG) begin
                    n_state = atss_pkg::ST_CH_DONE;
                end
            end
            atss_pkg::ST_CH_CMP: begin
                if (w_rate >= r_best_rate) begin
                    n_best = 8'(r_idx);
                    n_best_rate = w_rate;
                end
                n_idx = r_idx + 1'b1;
                w_raddr = n_idx[BW-1:0];
                if (n_idx >= NB || {1'b0, r_req} < 33'({1'b0, n_idx} + 33'd1) << UNIT_LOG) begin
                    n_state = atss_pkg::ST_CH_DONE;
                end
            end
            atss_pkg::ST_CH_DONE: begin
                n_last_req = r_req;
                n_last_b = r_best;
                n_out = 32'(({24'd0, r_best} + 32'd1) << UNIT_LOG);
                n_state = atss_pkg::ST_OUT;
            end
            atss_pkg::ST_RC_READ: begin
                if ({1'b0, r_it.unit_size} < w_min_size || w_bidx >= 32'(NUM_BUCKETS)) begin
                    n_state = atss_pkg::ST_IDLE;
                end else begin
                    n_idx = CW'(w_bidx[BW-1:0]);
                    w_raddr = w_bidx[BW-1:0];
                    n_mod = '0;
                    n_state = atss_pkg::ST_RC_WAIT;
                end
            end
            atss_pkg::ST_RC_WAIT: begin
                n_ent = r_rdata;
                n_ent.tb = r_rdata.tb + {32'd0, r_it.transferred_bytes};
                n_ent.tt = r_rdata.tt + {32'd0, r_it.delta_ticks};
                n_ent.hc = r_rdata.hc + 32'd1;
                n_per_b = r_per_b + {32'd0, r_it.transferred_bytes};
                n_per_t = r_per_t + {32'd0, r_it.delta_ticks};
                n_upd = r_upd + 32'd1;
                // hit count goes into the dividend shifter
                n_sh_b = {32'd0, n_ent.hc};
                n_mod = '0;
                n_step = '0;
                n_state = atss_pkg::ST_RC_UPD;
            end
            atss_pkg::ST_RC_UPD: begin
                // hit count mod term length, four dividend bits a cycle across all 32 bits
                w_rem = {2'b00, r_mod};
                w_sh  = r_sh_b[31:0];
                for (int k = 0; k < 4; k++) begin
                    w_rem = {w_rem[8:0], w_sh[31]};
                    w_sh  = {w_sh[30:0], 1'b0};
                    if (w_rem >= {1'b0, w_tl}) begin
                        w_rem = w_rem - {1'b0, w_tl};
                    end
                end
                n_mod  = w_rem[7:0];
                n_sh_b = {32'd0, w_sh};
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_fold = (w_rem == '0);
                    n_slow = !n_fold && (r_ent.tt >= {50'd0, i_slow_ticks});
                    n_state = atss_pkg::ST_RC_WB;
                end
            end
            atss_pkg::ST_RC_WB: begin
                w_we = 1'b1;
                w_wdata = r_ent;
                if (r_fold || r_slow) begin
                    w_wdata.bb = r_ent.bb + r_ent.tb;
                    w_wdata.bt = r_ent.bt + r_ent.tt;
                    w_wdata.tb = '0;
                    w_wdata.tt = '0;
                    if (r_slow && (({24'd0, r_last_b} + 32'd1) << UNIT_LOG) >
                        atss_pkg::SLOW_SIZE_LIMIT) begin
                        n_last_req = r_last_req - atss_pkg::SLOW_DECREMENT;
                    end else begin
                        n_last_req = '0;
                    end
                end
                n_state = atss_pkg::ST_IDLE;
                if ((r_upd & ((32'd1 << i_fraction_log) - 32'd1)) == '0) begin
                    n_avg = r_per_b >> atss_pkg::flog2(r_per_t);
                    n_sh_b = r_per_b >> i_fraction_log;
                    n_sh_t = r_per_t >> i_fraction_log;
                    n_idx = '0;
                    n_state = atss_pkg::ST_RB_READ;
                end
            end
            atss_pkg::ST_RB_READ: begin
                w_raddr = r_idx[BW-1:0];
                n_state = atss_pkg::ST_RB_WAIT;
            end
            atss_pkg::ST_RB_WAIT: begin
                n_ent = r_rdata;
                n_rebal = (w_rate >= r_avg);
                n_state = atss_pkg::ST_RB_WB;
            end
            atss_pkg::ST_RB_WB: begin
                w_we = 1'b1;
                w_wdata = r_ent;
                if (r_rebal) begin
                    w_wdata.bb = r_ent.bb - r_sh_b;
                    w_wdata.bt = r_ent.bt - r_sh_t;
                end else begin
                    w_wdata.bb = r_ent.bb + r_sh_b;
                    w_wdata.bt = r_ent.bt + r_sh_t;
                end
                n_idx = r_idx + 1'b1;
                n_state = atss_pkg::ST_RB_READ;
                if (r_idx == NB - 1'b1) begin
                    n_sum_b = r_sum_b + r_per_b;
                    n_sum_t = r_sum_t + r_per_t;
                    n_per_b = '0; n_per_t = '0; n_last_req = '0;
                    n_state = atss_pkg::ST_RB_END;
                end
            end
            atss_pkg::ST_RB_END: begin
                n_min = (w_ms <= {32'd0, i_default_rate}) ? 8'd0 :
                    8'(atss_pkg::MIN_BUCKET_SIZE >> UNIT_LOG);
                n_state = atss_pkg::ST_IDLE;
            end
            atss_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = atss_pkg::ST_IDLE;
                end
            end
            default: n_state = atss_pkg::ST_IDLE;
        endcase
    end

    assign o_valid = (r_state == atss_pkg::ST_OUT);
    assign o_transfer_size = r_out;
    assign o_busy = (r_state != atss_pkg::ST_IDLE) || i_item_valid;

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_best <= n_best; r_best_rate <= n_best_rate;
        r_req <= n_req; r_it <= n_it; r_ent <= n_ent; r_avg <= n_avg;
        r_sh_b <= n_sh_b; r_sh_t <= n_sh_t; r_out <= n_out;
        r_fold <= n_fold; r_slow <= n_slow; r_rebal <= n_rebal; r_mod <= n_mod;
        r_step <= n_step;
        if (!i_rst_n) begin
            // reset runs the table fill as an init command
            r_state <= atss_pkg::ST_INIT;
            r_idx <= '0;
            r_sum_b <= '0; r_sum_t <= '0;
            r_per_b <= '0; r_per_t <= '0; r_upd <= '0;
            r_last_req <= '0; r_min <= '0; r_last_b <= '0;
        end else begin
            r_state <= n_state;
            r_sum_b <= n_sum_b; r_sum_t <= n_sum_t;
            r_per_b <= n_per_b; r_per_t <= n_per_t; r_upd <= n_upd;
            r_last_req <= n_last_req; r_min <= n_min; r_last_b <= n_last_b;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/adaptive_transfer_size_selector.sv
//------------------------------------------------------------------------------
// adaptive_transfer_size_selector
// picks a transfer chunk size from measured per-bucket throughput
//------------------------------------------------------------------------------
//  channel   dir  signals                          payload
//  s_axis    in   s_axis_tvalid/tready/tdata       cmd, request_size, unit_size,
//                                                  transferred_bytes, start_tick, end_tick
//  m_axis    out  m_axis_tvalid/tready/tdata       transfer_size
//  cfg       in   i_cfg_we/i_cfg_index/i_cfg_data  register writes
//
//  choose: pop, read the starting bucket, compare each further bucket walked, settle,
//  then the result holds in the output register until taken
//  record: read, update, find hit count mod term length four bits a cycle, write back
//  a rebalance pass reads, checks and writes back each bucket, then sets the floor
//  after reset the tables are filled one bucket a cycle;
//  meanwhile the two-entry queue takes up to two transactions, then input stalls
//------------------------------------------------------------------------------
`default_nettype none

module adaptive_transfer_size_selector #(
    parameter int NUM_BUCKETS = atss_pkg::NUM_BUCKETS_DEF,
    parameter int UNIT_LOG    = atss_pkg::UNIT_LOG_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // cmd[1:0], request_size[33:2], unit_size[65:34], transferred_bytes[97:66],
    // start_tick[129:98], end_tick[161:130], zero fill
    input  wire logic [167:0]  s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // transfer_size[31:0]
    output logic [31:0]        m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);

    logic [31:0] r_default_rate;
    logic [7:0]  r_term_length;
    logic [3:0]  r_fraction_log;
    logic [13:0] r_ticks_per_second;
    logic [13:0] r_slow_ticks;

    atss_pkg::t_item w_item;
    logic w_item_valid, w_pop, w_busy, w_fill;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_rate     <= 32'd65536;
            r_term_length      <= 8'd16;
            r_fraction_log     <= 4'd6;
            r_ticks_per_second <= 14'd1000;
            r_slow_ticks       <= 14'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                atss_pkg::REG_DEFAULT_RATE: r_default_rate     <= i_cfg_data;
                atss_pkg::REG_TERM_LENGTH:  r_term_length      <= i_cfg_data[7:0];
                atss_pkg::REG_FRACTION_LOG: r_fraction_log     <= i_cfg_data[3:0];
                atss_pkg::REG_TICKS_PER_S:  r_ticks_per_second <= i_cfg_data[13:0];
                atss_pkg::REG_SLOW_TICKS:   r_slow_ticks       <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    logic w_front_ready;
    assign s_axis_tready = w_front_ready;
    assign w_fill = w_busy;

    atss_front u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (s_axis_tvalid),
        .o_ready             (w_front_ready),
        .i_cmd               (s_axis_tdata[1:0]),
        .i_request_size      (s_axis_tdata[33:2]),
        .i_unit_size         (s_axis_tdata[65:34]),
        .i_transferred_bytes (s_axis_tdata[97:66]),
        .i_start_tick        (s_axis_tdata[129:98]),
        .i_end_tick          (s_axis_tdata[161:130]),
        .o_item              (w_item),
        .o_item_valid        (w_item_valid),
        .i_item_pop          (w_pop)
    );

    atss_engine #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .UNIT_LOG    (UNIT_LOG)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_item             (w_item),
        .i_item_valid       (w_item_valid),
        .o_item_pop         (w_pop),
        .i_default_rate     (r_default_rate),
        .i_term_length      (r_term_length),
        .i_fraction_log     (r_fraction_log),
        .i_ticks_per_second (r_ticks_per_second),
        .i_slow_ticks       (r_slow_ticks),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_transfer_size    (m_axis_tdata),
        .o_busy             (w_busy)
    );

    // engine never pops an empty queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_item_valid) else $error("pop of empty queue");

    // a result stays stable until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");

    // meant to flag a pop while a result is pending, but w_fill is high whenever one is
    a_no_pop_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !w_pop || w_fill) else $error("pop during output");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
//------------------------------------------------------------------------------
// tb_top
// Self-checking testbench for adaptive_transfer_size_selector. Streams
// choose, record, reinitialize and unused commands into the block. An
// in-bench model of the bucket tables predicts every chunk size, and each
// returned size is compared in order. Register settings are swept between
// phases, with low and high extreme settings among them.
//------------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB    = 64;
    localparam int ULOG  = 10;
    localparam int DRAIN = 1000;  // covers three queued records that each rebalance

    // one input transaction
    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] req;
        logic [31:0] unit;
        logic [31:0] nbytes;
        logic [31:0] t0;
        logic [31:0] t1;
    } xfer_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [31:0]  m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    adaptive_transfer_size_selector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit, far above the slowest legal run
    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    //--------------------------------------------------------------------------
    // predictor state: registers and bucket tables
    //--------------------------------------------------------------------------
    logic [31:0] cfg_rate;
    logic [7:0]  cfg_term;
    logic [3:0]  cfg_frac;
    logic [13:0] cfg_tps;
    logic [13:0] cfg_slow;

    logic [63:0] bkt_bytes [NB];
    logic [63:0] bkt_ticks [NB];
    logic [63:0] trm_bytes [NB];
    logic [63:0] trm_ticks [NB];
    logic [31:0] hits      [NB];
    logic [63:0] tot_bytes, tot_ticks, per_bytes, per_ticks;
    logic [31:0] n_updates, prev_req;
    logic [7:0]  floor_bkt, prev_bkt;

    logic [31:0] size_q [$];      // chunk sizes still owed by the block
    int          errors = 0;
    int          n_choose = 0, n_record = 0, n_other = 0, n_sizes = 0;
    int          burst_left = 0;

    // floor log2, zero for zero
    function automatic int unsigned msb_pos(logic [63:0] v);
        int unsigned n = 0;
        for (int i = 1; i < 64; i++) begin
            if (v[i]) begin
                n = i;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] bkt_rate(int unsigned b);
        return bkt_bytes[b] >> msb_pos(bkt_ticks[b]);
    endfunction

    function automatic logic [63:0] bkt_size(logic [7:0] b);
        return (64'(b) + 64'd1) << ULOG;
    endfunction

    function automatic void clear_tables();
        tot_bytes = '0;
        tot_ticks = '0;
        for (int b = 0; b < NB; b++) begin
            bkt_bytes[b] = 64'(cfg_rate);
            bkt_ticks[b] = 64'(cfg_tps);
            trm_bytes[b] = '0;
            trm_ticks[b] = '0;
            hits[b]      = '0;
            tot_bytes += bkt_bytes[b];
            tot_ticks += bkt_ticks[b];
        end
        per_bytes = '0;
        per_ticks = '0;
        n_updates = '0;
        floor_bkt = '0;
        prev_req  = '0;
        prev_bkt  = '0;
    endfunction

    // chunk size for a request; a bucket walk updates the remembered choice
    function automatic logic [31:0] pick_size(logic [31:0] req);
        int unsigned best;
        if (64'(req) < bkt_size(floor_bkt)) begin
            return req;
        end
        best = floor_bkt;
        if (prev_req != 0) begin
            if (prev_req >= req) begin
                return 32'(bkt_size(prev_bkt));
            end
            best = prev_bkt;
        end
        for (int unsigned b = best + 1; b < NB; b++) begin
            if (64'(req) < bkt_size(8'(b))) begin
                break;
            end
            if (bkt_rate(b) >= bkt_rate(best)) begin
                best = b;
            end
        end
        prev_req = req;
        prev_bkt = 8'(best);
        return 32'(bkt_size(8'(best)));
    endfunction

    function automatic void fold_term(int unsigned b);
        bkt_bytes[b] += trm_bytes[b];
        bkt_ticks[b] += trm_ticks[b];
        trm_bytes[b] = '0;
        trm_ticks[b] = '0;
    endfunction

    // finished transfer: term totals, folds and periodic rebalance
    function automatic void log_transfer(xfer_t x);
        logic [31:0] dt;
        logic [31:0] idx;
        logic [31:0] tl;
        logic [63:0] avg;
        logic [31:0] mask;
        dt = x.t1 - x.t0;
        if (64'(x.unit) < bkt_size(floor_bkt)) begin
            return;
        end
        idx = (x.unit >> ULOG) - 32'd1;
        if (idx >= NB) begin
            return;
        end
        per_bytes += 64'(x.nbytes);
        per_ticks += 64'(dt);
        n_updates++;
        trm_bytes[idx] += 64'(x.nbytes);
        trm_ticks[idx] += 64'(dt);
        hits[idx]++;
        tl = (cfg_term == 0) ? 32'd256 : 32'(cfg_term);
        if (hits[idx] % tl == 0) begin
            prev_req = '0;
            fold_term(idx);
        end else if (trm_ticks[idx] >= 64'(cfg_slow)) begin
            // slow link: back off the remembered request when the remembered chunk size was large
            if (bkt_size(prev_bkt) > 64'(atss_pkg::SLOW_SIZE_LIMIT)) begin
                prev_req -= atss_pkg::SLOW_DECREMENT;
            end else begin
                prev_req = '0;
            end
            fold_term(idx);
        end
        mask = (32'd1 << cfg_frac) - 32'd1;
        if ((n_updates & mask) == 0) begin
            avg = per_bytes >> msb_pos(per_ticks);
            for (int b = 0; b < NB; b++) begin
                if (bkt_rate(b) >= avg) begin
                    bkt_bytes[b] -= per_bytes >> cfg_frac;
                    bkt_ticks[b] -= per_ticks >> cfg_frac;
                end else begin
                    bkt_bytes[b] += per_bytes >> cfg_frac;
                    bkt_ticks[b] += per_ticks >> cfg_frac;
                end
            end
            tot_bytes += per_bytes;
            tot_ticks += per_ticks;
            per_bytes = '0;
            per_ticks = '0;
            prev_req  = '0;
            if ((tot_bytes >> (msb_pos(tot_ticks) >> msb_pos(64'(cfg_tps))))
                    <= 64'(cfg_rate)) begin
                floor_bkt = '0;
            end else begin
                floor_bkt = 8'(atss_pkg::MIN_BUCKET_SIZE >> ULOG);
            end
        end
    endfunction

    function automatic void predict(xfer_t x);
        case (x.cmd)
            atss_pkg::CMD_CHOOSE: begin
                size_q.push_back(pick_size(x.req));
                n_choose++;
            end
            atss_pkg::CMD_RECORD: begin
                log_transfer(x);
                n_record++;
            end
            atss_pkg::CMD_INIT: begin
                clear_tables();
                n_other++;
            end
            default: begin
                n_other++;   // unused command, nothing happens
            end
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // result checking
    //--------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (size_q.size() == 0) begin
                $error("unexpected result transaction, transfer_size %0d", m_axis_tdata);
                errors++;
            end else begin
                logic [31:0] want;
                want = size_q.pop_front();
                n_sizes++;
                if (m_axis_tdata !== want) begin
                    $error("transfer_size mismatch: expected %0d actual %0d",
                           want, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure: modes of full rate, light and heavy stalls
    int rx_mode = 0;
    int rx_count = 0;
    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_mode  <= $urandom_range(0, 2);
            rx_count <= $urandom_range(20, 300);
            m_axis_tready <= 1'b1;
        end else begin
            rx_count <= rx_count - 1;
            case (rx_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // stimulus helpers
    //--------------------------------------------------------------------------
    // drive one transaction; tvalid drops in the accept step when the burst ends or hold_off is set
    task automatic send_item(input xfer_t x, input bit hold_off);
        int gap;
        s_axis_tdata  <= {6'b0, x.t1, x.t0, x.nbytes, x.unit, x.req, x.cmd};
        s_axis_tvalid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        predict(x);
        if (burst_left > 0 && !hold_off) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (!hold_off) begin
                gap = ($urandom_range(0, 2) == 0) ? $urandom_range(60, 400)
                                                  : $urandom_range(1, 12);
                repeat (gap) @(posedge i_clk);
            end else begin
                @(posedge i_clk);
            end
        end
    endtask

    // wait until every owed size has come and the engine has settled
    task automatic drain();
        while (size_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // write all five registers on back-to-back cycles, block idle
    task automatic set_regs(input logic [31:0] rate, input logic [7:0] term,
                            input logic [3:0] frac, input logic [13:0] tps,
                            input logic [13:0] slow);
        logic [2:0]  idx [5];
        logic [31:0] val [5];
        idx = '{atss_pkg::REG_DEFAULT_RATE, atss_pkg::REG_TERM_LENGTH,
                atss_pkg::REG_FRACTION_LOG, atss_pkg::REG_TICKS_PER_S,
                atss_pkg::REG_SLOW_TICKS};
        val = '{rate, 32'(term), 32'(frac), 32'(tps), 32'(slow)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_rate = rate;
        cfg_term = term;
        cfg_frac = frac;
        cfg_tps  = tps;
        cfg_slow = slow;
    endtask

    function automatic xfer_t mk(logic [1:0] c, logic [31:0] r, logic [31:0] u,
                                 logic [31:0] n, logic [31:0] a, logic [31:0] e);
        xfer_t x;
        x.cmd = c; x.req = r; x.unit = u; x.nbytes = n; x.t0 = a; x.t1 = e;
        return x;
    endfunction

    // random transaction, biased toward in-range buckets and short transfers
    function automatic xfer_t rand_item();
        xfer_t x;
        int    sel;
        sel   = $urandom_range(0, 99);
        x.cmd = (sel < 55) ? atss_pkg::CMD_CHOOSE : (sel < 98) ? atss_pkg::CMD_RECORD
              : (sel < 99) ? atss_pkg::CMD_INIT : 2'd3;
        x.req = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 70000);
        x.unit = ($urandom_range(0, 9) == 0) ? $urandom()
               : (32'($urandom_range(1, 64)) << ULOG) + $urandom_range(0, 1023);
        x.nbytes = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 1 << 20);
        x.t0 = $urandom();
        x.t1 = ($urandom_range(0, 9) == 0) ? $urandom() : x.t0 + $urandom_range(0, 300);
        return x;
    endfunction

    task automatic run_random(input int n);
        for (int k = 0; k < n; k++) begin
            send_item(rand_item(), k == n - 1);
        end
    endtask

    //--------------------------------------------------------------------------
    // tests
    //--------------------------------------------------------------------------
    // extremes of every field and each corner of the algorithm, reset registers
    task automatic test_directed();
        xfer_t d [$];
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd0, 0, 0, 0, 0));          // tiny request
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd1024, 0, 0, 0, 0));       // first bucket
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'hFFFF_FFFF, 0, 0, 0, 0));  // walks all
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd5000, 0, 0, 0, 0));       // reuse choice
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'd0, 32'd100, 0, 5));    // unit too small
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       0, 9));                                             // past end
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'd65536 + 1024, 32'd7, 0, 1)); // past end
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'd65536 + 1023, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'd0));                             // last bucket
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'd2048, 32'd4096,
                       32'd500, 32'd10));                                  // reversed
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd40000, 0, 0, 0, 0));      // large choice
        d.push_back(mk(atss_pkg::CMD_RECORD, 0, 32'd3072, 32'd9000,
                       32'd0, 32'd200));                                   // slow link
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd39000, 0, 0, 0, 0));
        d.push_back(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF));                     // unused cmd
        d.push_back(mk(atss_pkg::CMD_INIT, 0, 0, 0, 0, 0));                // reinitialize
        d.push_back(mk(atss_pkg::CMD_CHOOSE, 32'd12345, 0, 0, 0, 0));
        foreach (d[k]) begin
            send_item(d[k], k == d.size() - 1);
        end
        drain();
    endtask

    // one register setting: write, reinitialize, random traffic
    task automatic test_setting(input logic [31:0] rate, input logic [7:0] term,
                                input logic [3:0] frac, input logic [13:0] tps,
                                input logic [13:0] slow, input int n);
        set_regs(rate, term, frac, tps, slow);
        send_item(mk(atss_pkg::CMD_INIT, 0, 0, 0, 0, 0), 1'b1);
        run_random(n);
        drain();
    endtask

    // sender stops mid-traffic until every owed size has come back
    task automatic test_pause();
        run_random(120);
        while (size_q.size() != 0) @(posedge i_clk);
        run_random(120);
        drain();
    endtask

    initial begin
        cfg_rate = 32'd65536;
        cfg_term = 8'd16;
        cfg_frac = 4'd6;
        cfg_tps  = 14'd1000;
        cfg_slow = 14'd100;
        clear_tables();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pause();
        // low registers: zero rate, term length and fraction log, rebalance on every record
        test_setting(32'd0, 8'd0, 4'd0, 14'd1, 14'd1, 200);
        // high registers: full rate, term length and fraction log
        test_setting(32'hFFFF_FFFF, 8'd255, 4'd15, 14'd10000, 14'd10000, 200);
        test_setting(32'd4096, 8'd3, 4'd2, 14'd64, 14'd150, 200);
        test_setting($urandom(), 8'($urandom_range(1, 255)), 4'($urandom_range(0, 15)),
                     14'($urandom_range(1, 10000)), 14'($urandom_range(1, 10000)), 200);

        if (size_q.size() != 0) begin
            $error("%0d expected transfer sizes never arrived", size_q.size());
            errors++;
        end
        $display("covered %0d choose, %0d record and %0d other transactions",
                 n_choose, n_record, n_other);
        $display("checked %0d transfer sizes over five register settings", n_sizes);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: adaptive_transfer_size_selector.f
rtl/atss_pkg.sv
rtl/atss_front.sv
rtl/atss_engine.sv
rtl/adaptive_transfer_size_selector.sv
dv/tb_top.sv
